>>> src/tfb_pkg.sv
// shared types and constants for the telemetry frame builder
package tfb_pkg;

   localparam int DATA_BYTES  = 17;  // longest frame before the two check bytes
   localparam int FRAME_BYTES = 19;  // longest frame including check bytes
   localparam int NUM_WORDS   = 6;
   localparam int CNT_W       = 5;

   localparam logic [7:0] FRAME_HEADER  = 8'hAA;
   localparam logic [7:0] DEST_RESET    = 8'hFF;

   localparam logic [7:0] CODE_ATTITUDE = 8'h03;
   localparam logic [7:0] CODE_RC       = 8'hF1;
   localparam logic [7:0] CODE_MOTOR    = 8'hF2;
   localparam logic [7:0] CODE_RAW      = 8'h01;

   localparam logic [7:0] LEN_ATTITUDE  = 8'd7;
   localparam logic [7:0] LEN_RC        = 8'd12;
   localparam logic [7:0] LEN_MOTOR     = 8'd8;
   localparam logic [7:0] LEN_RAW       = 8'd13;

   localparam logic [7:0] ATTITUDE_STATE = 8'h01;
   localparam logic [7:0] RAW_TRAILER    = 8'h00;

   // bytes ahead of the check bytes, per kind
   localparam logic [CNT_W-1:0] ND_ATTITUDE = 5'd11;
   localparam logic [CNT_W-1:0] ND_RC       = 5'd16;
   localparam logic [CNT_W-1:0] ND_MOTOR    = 5'd12;
   localparam logic [CNT_W-1:0] ND_RAW      = 5'd17;

   // remote-control scaling, kept modulo 2^16
   localparam logic [15:0] RC_RP_SCALE  = 16'd2000;
   localparam logic [15:0] RC_RP_OFS    = 16'd1000;
   localparam logic [15:0] RC_YAW_SCALE = 16'd1000;
   localparam logic [15:0] RC_YAW_OFS   = 16'd500;

   typedef enum logic [1:0] {
      KIND_ATTITUDE = 2'd0,
      KIND_RC       = 2'd1,
      KIND_MOTOR    = 2'd2,
      KIND_RAW      = 2'd3
   } frame_kind_type;

   typedef logic [NUM_WORDS-1:0][15:0]  word_set_type;
   typedef logic [DATA_BYTES-1:0][7:0]  data_bytes_type;
   typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_type;

endpackage

>>> src/telemetry_frame_builder_core.sv
// telemetry frame builder: five-stage pipeline from value set to serialized frame bytes
//
// Each accepted request becomes one frame: header 0xAA, destination address, function
// code, length, little-endian payload, then an 8-bit sum and an 8-bit sum of running sums.
// Frames are 13 (attitude), 14 (motor), 18 (remote control) or 19 (raw inertial) bytes
// long and leave one byte per cycle on the rsp channel unless rsp_ready holds them back,
// last_byte marking the second check byte. A request passes scaling, byte assembly,
// partial checksums and checksum merge before it reaches the byte shifter, which feeds
// the output register. Up to four requests are buffered in the stages while a frame is
// being sent; throughput is set by the single byte shifter in front of the output
// register. The destination address (dest_ff) resets to 0xFF and is sampled when a
// request is assembled.
module telemetry_frame_builder_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic signed [15:0]   req_value_a,
   input  logic signed [15:0]   req_value_b,
   input  logic signed [15:0]   req_value_c,
   input  logic signed [15:0]   req_value_d,
   input  logic signed [15:0]   req_value_e,
   input  logic signed [15:0]   req_value_f,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_frame_byte,
   output logic                 rsp_last_byte
);
   import tfb_pkg::*;

   // configuration
   logic [7:0] dest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff <= DEST_RESET;
      end else if (csr_wr_en) begin
         dest_ff <= csr_wr_data;
      end
   end

   // stage control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, ser_valid_ff, rsp_valid_ff;
   logic s1_load, s2_load, s3_load, s4_load, ser_load, out_load;
   logic emit, ser_done;
   logic [CNT_W-1:0] ser_rem_ff;

   assign out_load = !rsp_valid_ff || rsp_ready;
   assign emit     = ser_valid_ff && out_load;
   assign ser_done = emit && (ser_rem_ff == 5'd1);
   assign ser_load = !ser_valid_ff || ser_done;
   assign s4_load  = !s4_valid_ff || ser_load;
   assign s3_load  = !s3_valid_ff || s4_load;
   assign s2_load  = !s2_valid_ff || s3_load;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign req_ready = s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         ser_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load)  s1_valid_ff  <= req_valid;
         if (s2_load)  s2_valid_ff  <= s1_valid_ff;
         if (s3_load)  s3_valid_ff  <= s2_valid_ff;
         if (s4_load)  s4_valid_ff  <= s3_valid_ff;
         if (ser_load) ser_valid_ff <= s4_valid_ff;
         if (out_load) rsp_valid_ff <= ser_valid_ff;
      end
   end

   // stage 1: remote-control scaling
   frame_kind_type s1_kind_ff;
   word_set_type   s1_words_ff;
   word_set_type   s1_words_in;
   frame_kind_type req_kind;

   assign req_kind = frame_kind_type'(req_type);

   always_comb begin
      s1_words_in[0] = $unsigned(req_value_a);
      s1_words_in[1] = $unsigned(req_value_b);
      s1_words_in[2] = $unsigned(req_value_c);
      s1_words_in[3] = $unsigned(req_value_d);
      s1_words_in[4] = $unsigned(req_value_e);
      s1_words_in[5] = $unsigned(req_value_f);
      if (req_kind == KIND_RC) begin
         s1_words_in[0] = 16'($unsigned(req_value_a) * RC_RP_SCALE) - RC_RP_OFS;
         s1_words_in[1] = 16'($unsigned(req_value_b) * RC_RP_SCALE) - RC_RP_OFS;
         s1_words_in[3] = 16'($unsigned(req_value_d) * RC_YAW_SCALE) - RC_YAW_OFS;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_kind_ff  <= req_kind;
         s1_words_ff <= s1_words_in;
      end
   end

   // stage 2: byte assembly
   data_bytes_type   s2_bytes_ff, s2_bytes_in;
   logic [CNT_W-1:0] s2_nd_ff, s2_nd_in;

   always_comb begin
      s2_bytes_in    = '0;
      s2_bytes_in[0] = FRAME_HEADER;
      s2_bytes_in[1] = dest_ff;
      for (int w = 0; w < NUM_WORDS; w++) begin
         s2_bytes_in[4 + 2*w] = s1_words_ff[w][7:0];
         s2_bytes_in[5 + 2*w] = s1_words_ff[w][15:8];
      end
      unique case (s1_kind_ff)
         KIND_ATTITUDE: begin
            s2_bytes_in[2] = CODE_ATTITUDE;
            s2_bytes_in[3] = LEN_ATTITUDE;
            s2_bytes_in[10] = ATTITUDE_STATE;
            for (int k = 11; k < DATA_BYTES; k++) s2_bytes_in[k] = '0;
            s2_nd_in = ND_ATTITUDE;
         end
         KIND_RC: begin
            s2_bytes_in[2] = CODE_RC;
            s2_bytes_in[3] = LEN_RC;
            s2_nd_in = ND_RC;
         end
         KIND_MOTOR: begin
            s2_bytes_in[2] = CODE_MOTOR;
            s2_bytes_in[3] = LEN_MOTOR;
            for (int k = 12; k < DATA_BYTES; k++) s2_bytes_in[k] = '0;
            s2_nd_in = ND_MOTOR;
         end
         KIND_RAW: begin
            s2_bytes_in[2] = CODE_RAW;
            s2_bytes_in[3] = LEN_RAW;
            s2_bytes_in[16] = RAW_TRAILER;
            s2_nd_in = ND_RAW;
         end
         default: begin
            s2_nd_in = ND_RAW;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_bytes_ff <= s2_bytes_in;
         s2_nd_ff    <= s2_nd_in;
      end
   end

   // stage 3: partial sums; padding zeros make a fixed weight of 17 - i per byte
   data_bytes_type   s3_bytes_ff;
   logic [CNT_W-1:0] s3_nd_ff;
   logic [7:0] s3_sum_lo_ff, s3_sum_hi_ff, s3_wt_lo_ff, s3_wt_hi_ff;
   logic [7:0] s3_sum_lo_in, s3_sum_hi_in, s3_wt_lo_in, s3_wt_hi_in;

   always_comb begin
      s3_sum_lo_in = '0;
      s3_sum_hi_in = '0;
      s3_wt_lo_in  = '0;
      s3_wt_hi_in  = '0;
      for (int i = 0; i < 9; i++) begin
         s3_sum_lo_in = s3_sum_lo_in + s2_bytes_ff[i];
         s3_wt_lo_in  = s3_wt_lo_in + 8'(s2_bytes_ff[i] * 8'(DATA_BYTES - i));
      end
      for (int i = 9; i < DATA_BYTES; i++) begin
         s3_sum_hi_in = s3_sum_hi_in + s2_bytes_ff[i];
         s3_wt_hi_in  = s3_wt_hi_in + 8'(s2_bytes_ff[i] * 8'(DATA_BYTES - i));
      end
   end

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_bytes_ff  <= s2_bytes_ff;
         s3_nd_ff     <= s2_nd_ff;
         s3_sum_lo_ff <= s3_sum_lo_in;
         s3_sum_hi_ff <= s3_sum_hi_in;
         s3_wt_lo_ff  <= s3_wt_lo_in;
         s3_wt_hi_ff  <= s3_wt_hi_in;
      end
   end

   // stage 4: merge checks and place them behind the data
   frame_bytes_type  s4_frame_ff, s4_frame_in;
   logic [CNT_W-1:0] s4_len_ff, s4_len_in;
   logic [7:0]       chk_sum, chk_fold, chk_corr;
   logic [CNT_W-1:0] nd_pad, nd_next;

   always_comb begin
      nd_pad   = 5'(DATA_BYTES) - s3_nd_ff;
      nd_next  = s3_nd_ff + 5'd1;
      chk_sum  = s3_sum_lo_ff + s3_sum_hi_ff;
      // each padding slot added the full sum once more
      chk_corr = 8'(chk_sum * {3'b000, nd_pad});
      chk_fold = s3_wt_lo_ff + s3_wt_hi_ff - chk_corr;
      s4_len_in = s3_nd_ff + 5'd2;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (i < DATA_BYTES) s4_frame_in[i] = s3_bytes_ff[i];
         else                s4_frame_in[i] = '0;
         if (5'(i) == s3_nd_ff)     s4_frame_in[i] = chk_sum;
         else if (5'(i) == nd_next) s4_frame_in[i] = chk_fold;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_load) begin
         s4_frame_ff <= s4_frame_in;
         s4_len_ff   <= s4_len_in;
      end
   end

   // stage 5: byte shifter
   frame_bytes_type ser_buf_ff;
   logic [7:0]      rsp_frame_byte_ff;
   logic            rsp_last_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_rem_ff <= '0;
      end else if (ser_load && s4_valid_ff) begin
         ser_rem_ff <= s4_len_ff;
      end else if (emit) begin
         ser_rem_ff <= ser_rem_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load && s4_valid_ff) begin
         ser_buf_ff <= s4_frame_ff;
      end else if (emit) begin
         ser_buf_ff <= {8'h00, ser_buf_ff[FRAME_BYTES-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_frame_byte_ff <= ser_buf_ff[0];
         rsp_last_byte_ff  <= (ser_rem_ff == 5'd1);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_frame_byte_ff;
   assign rsp_last_byte  = rsp_last_byte_ff;

   // checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && ser_valid_ff))
      else $error("request stalled with a free pipeline stage");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> (ser_rem_ff != 5'd0 && ser_rem_ff <= 5'(FRAME_BYTES)))
      else $error("byte shifter count out of range");

   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (s4_len_ff == 5'd13 || s4_len_ff == 5'd14 ||
                       s4_len_ff == 5'd18 || s4_len_ff == 5'd19))
      else $error("illegal frame length");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      ser_done |=> (rsp_valid_ff && rsp_last_byte_ff))
      else $error("last byte flag not set on final transfer of frame");

endmodule
